// ===== rtl/core/ycm_pkg.sv =====
// ----------------------------------------------------------------------------
// ycm_pkg
// Shared types, field codes and packing helpers for the Y-cable mode controller.
// ----------------------------------------------------------------------------
package ycm_pkg;

    localparam int VOLT_W     = 12;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int FUNC_W     = 2;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ADC_PRESENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OTG_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OTG_MAX     = 3'd4;

    // Register reset values
    localparam logic              RST_ADC_PRESENT = 1'b1;
    localparam logic [VOLT_W-1:0] RST_CHARGE_MIN  = 12'd600;
    localparam logic [VOLT_W-1:0] RST_CHARGE_MAX  = 12'd1200;
    localparam logic [VOLT_W-1:0] RST_OTG_MIN     = 12'd0;
    localparam logic [VOLT_W-1:0] RST_OTG_MAX     = 12'd300;

    // Input kinds
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CHARGER = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ID      = 2'd2;

    // Charger-type events
    localparam logic [2:0] CHG_NONE    = 3'd0;
    localparam logic [2:0] CHG_SDP     = 3'd1;
    localparam logic [2:0] CHG_UNKNOWN = 3'd4;
    localparam logic [2:0] CHG_PROVIDE = 3'd5;

    // ID pin events
    localparam logic [1:0] ID_FALL = 2'd0;
    localparam logic [1:0] ID_RISE = 2'd1;

    // Notification codes
    localparam logic [1:0] NOTIFY_NO_CHARGER = 2'd0;
    localparam logic [1:0] NOTIFY_CHARGER    = 2'd1;
    localparam logic [1:0] NOTIFY_POWER      = 2'd2;

    // Reschedule requests
    localparam logic [1:0] SCHED_NONE   = 2'd0;
    localparam logic [1:0] SCHED_POLL   = 2'd1;
    localparam logic [1:0] SCHED_SWITCH = 2'd2;
    localparam logic [1:0] SCHED_NOW    = 2'd3;

    // ID line classes
    localparam logic [1:0] CLASS_HIGH    = 2'd0;
    localparam logic [1:0] CLASS_OTG     = 2'd1;
    localparam logic [1:0] CLASS_CHARGE  = 2'd2;
    localparam logic [1:0] CLASS_INVALID = 2'd3;

    // Reported mode codes
    localparam logic [1:0] MODE_CODE_UNKNOWN = 2'd0;
    localparam logic [1:0] MODE_CODE_CHARGER = 2'd1;
    localparam logic [1:0] MODE_CODE_OTG     = 2'd2;

    typedef enum logic [2:0] {
        MODE_UNKNOWN = 3'b001,
        MODE_CHARGER = 3'b010,
        MODE_OTG     = 3'b100
    } mode_t;

    typedef struct packed {
        logic              adc_present;
        logic [VOLT_W-1:0] charge_min;
        logic [VOLT_W-1:0] charge_max;
        logic [VOLT_W-1:0] otg_min;
        logic [VOLT_W-1:0] otg_max;
    } cfg_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              gpio_read_fail;
        logic              id_pin_high;
        logic [VOLT_W-1:0] id_mv;
        logic [2:0]        charger_event;
        logic [1:0]        id_event;
    } item_t;

    typedef struct packed {
        logic       notify_valid;
        logic [1:0] notify_code;
        logic [1:0] schedule;
        logic       cancel_poll;
        logic [1:0] mode_out;
        logic [1:0] id_class;
        logic       charger_flag_out;
        logic       otg_flag_out;
        logic       devoff_done_out;
    } result_t;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] code;
        case (m)
            MODE_CHARGER: code = MODE_CODE_CHARGER;
            MODE_OTG:     code = MODE_CODE_OTG;
            default:      code = MODE_CODE_UNKNOWN;
        endcase
        return code;
    endfunction

    function automatic item_t unpack_item(input logic [FUNC_W-1:0] tuser,
                                          input logic [S_TDATA_W-1:0] tdata);
        item_t it;
        it.func           = tuser;
        it.gpio_read_fail = tdata[0];
        it.id_pin_high    = tdata[1];
        it.id_mv          = tdata[13:2];
        it.charger_event  = tdata[16:14];
        it.id_event       = tdata[18:17];
        return it;
    endfunction

    function automatic logic [M_TDATA_W-1:0] pack_result(input result_t r);
        logic [M_TDATA_W-1:0] d;
        d        = '0;
        d[0]     = r.notify_valid;
        d[2:1]   = r.notify_code;
        d[4:3]   = r.schedule;
        d[5]     = r.cancel_poll;
        d[7:6]   = r.mode_out;
        d[9:8]   = r.id_class;
        d[10]    = r.charger_flag_out;
        d[11]    = r.otg_flag_out;
        d[12]    = r.devoff_done_out;
        return d;
    endfunction

endpackage

// ===== rtl/core/y_cable_mode_controller_unit.sv =====
// ----------------------------------------------------------------------------
// y_cable_mode_controller_unit
// Y-cable mode controller: ID line classification and charger/OTG mode control.
// ----------------------------------------------------------------------------
// Each accepted item (monitor tick, charger-type event or ID pin event) gives
// exactly one result, in order. An item is captured in the input register,
// decided by the combinational window compare and mode logic, and lands
// in the result register, which drives m_tvalid, once that register is free.
// The block sustains 1 item per cycle while m_tready is held high, bounded
// only by the single decision stage that also updates mode and enable flags.
// The input side keeps taking items while a result waits on m_tready, until
// both the input and result registers are full. Configuration writes
// take effect on the next cycle and are meant to be made while no item
// is in flight.
// ----------------------------------------------------------------------------
module y_cable_mode_controller_unit #(
    parameter int ADC_BITS = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [ycm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ycm_pkg::CFG_W-1:0]         cfg_wdata,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [0] gpio_read_fail, [1] id_pin_high, [13:2] id_mv,
    // [16:14] charger_event, [18:17] id_event, [23:19] zero
    input  logic [ycm_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] func
    input  logic [ycm_pkg::FUNC_W-1:0]        s_tuser,
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] notify_valid, [2:1] notify_code, [4:3] schedule, [5] cancel_poll,
    // [7:6] mode_out, [9:8] id_class, [10] charger_flag_out,
    // [11] otg_flag_out, [12] devoff_done_out, [15:13] zero
    output logic [ycm_pkg::M_TDATA_W-1:0]     m_tdata
);
    import ycm_pkg::*;

    cfg_t                 cfg_reg;
    logic                 in_valid_reg;
    item_t                in_item_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic                 step;      // decision stage moves an item to the result reg
    logic [1:0]           id_class;
    result_t              res;

    // --- configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.adc_present <= RST_ADC_PRESENT;
            cfg_reg.charge_min  <= RST_CHARGE_MIN;
            cfg_reg.charge_max  <= RST_CHARGE_MAX;
            cfg_reg.otg_min     <= RST_OTG_MIN;
            cfg_reg.otg_max     <= RST_OTG_MAX;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ADC_PRESENT: cfg_reg.adc_present <= cfg_wdata[0];
                REG_CHARGE_MIN:  cfg_reg.charge_min  <= cfg_wdata[VOLT_W-1:0];
                REG_CHARGE_MAX:  cfg_reg.charge_max  <= cfg_wdata[VOLT_W-1:0];
                REG_OTG_MIN:     cfg_reg.otg_min     <= cfg_wdata[VOLT_W-1:0];
                REG_OTG_MAX:     cfg_reg.otg_max     <= cfg_wdata[VOLT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // --- handshake: result reg frees on m transfer, input reg frees on step
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= unpack_item(s_tuser, s_tdata);
        end
    end

    // --- decision stage
    ycm_classify #(
        .ADC_BITS (ADC_BITS)
    ) u_classify (
        .cfg       (cfg_reg),
        .id_mv     (in_item_reg.id_mv),
        .id_class  (id_class)
    );

    ycm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .item     (in_item_reg),
        .id_class (id_class),
        .res      (res)
    );

    // --- result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= pack_result(res);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/core/ycm_classify.sv =====
// ----------------------------------------------------------------------------
// ycm_classify
// Sorts the ID line voltage into high / OTG / charge / invalid by window compare.
// ----------------------------------------------------------------------------
module ycm_classify #(
    parameter int ADC_BITS = 12
) (
    input  ycm_pkg::cfg_t                    cfg,
    input  logic [ycm_pkg::VOLT_W-1:0]       id_mv,
    output logic [1:0]                       id_class
);
    import ycm_pkg::*;

    localparam int VAL_W = (ADC_BITS < VOLT_W) ? ADC_BITS : VOLT_W;
    localparam logic [VOLT_W-1:0] VAL_MASK = VOLT_W'((64'd1 << VAL_W) - 64'd1);

    logic [VOLT_W-1:0] volt;
    logic              in_charge;
    logic              in_otg;

    assign volt      = id_mv & VAL_MASK;
    assign in_charge = (volt >= cfg.charge_min) && (volt <= cfg.charge_max);
    assign in_otg    = (volt >= cfg.otg_min) && (volt <= cfg.otg_max);

    always_comb begin
        if (!cfg.adc_present) begin
            id_class = CLASS_INVALID;
        end else if (in_charge) begin
            id_class = CLASS_CHARGE;
        end else if (in_otg) begin
            id_class = CLASS_OTG;
        end else if (volt >= cfg.charge_max) begin
            id_class = CLASS_HIGH;
        end else begin
            id_class = CLASS_INVALID;
        end
    end

endmodule

// ===== rtl/core/ycm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ycm_ctrl
// Mode state and enable flags; decides notification and reschedule per item.
// ----------------------------------------------------------------------------
module ycm_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  ycm_pkg::item_t   item,
    input  logic [1:0]       id_class,
    output ycm_pkg::result_t res
);
    import ycm_pkg::*;

    mode_t mode_reg, mode_next;
    logic  chg_en_reg, chg_en_next;
    logic  otg_en_reg, otg_en_next;
    logic  devoff_reg, devoff_next;

    logic       nvalid;
    logic [1:0] ncode;
    logic [1:0] sched;
    logic       cancel;
    logic [1:0] cls;
    logic       stop;

    always_comb begin
        mode_next   = mode_reg;
        chg_en_next = chg_en_reg;
        otg_en_next = otg_en_reg;
        devoff_next = devoff_reg;
        nvalid      = 1'b0;
        ncode       = NOTIFY_NO_CHARGER;
        sched       = SCHED_NONE;
        cancel      = 1'b0;
        cls         = CLASS_INVALID;
        stop        = 1'b0;

        case (item.func)
            FUNC_TICK: begin
                if (item.gpio_read_fail || item.id_pin_high) begin
                    stop = 1'b1;
                end else begin
                    cls   = id_class;
                    sched = SCHED_POLL;
                    if (id_class == CLASS_CHARGE && mode_reg != MODE_CHARGER) begin
                        nvalid = 1'b1;
                        if (otg_en_reg) begin
                            // leave OTG first, then retry after the switch delay
                            otg_en_next = 1'b0;
                            mode_next   = MODE_UNKNOWN;
                            sched       = SCHED_SWITCH;
                        end else begin
                            mode_next   = MODE_CHARGER;
                            chg_en_next = 1'b1;
                            ncode       = NOTIFY_CHARGER;
                        end
                    end else if (id_class == CLASS_OTG && mode_reg != MODE_OTG) begin
                        nvalid = 1'b1;
                        if (chg_en_reg) begin
                            chg_en_next = 1'b0;
                            mode_next   = MODE_UNKNOWN;
                            sched       = SCHED_SWITCH;
                        end else begin
                            mode_next   = MODE_OTG;
                            otg_en_next = 1'b1;
                            ncode       = NOTIFY_POWER;
                        end
                    end else if (id_class == CLASS_HIGH || id_class == CLASS_INVALID) begin
                        stop = 1'b1;
                    end
                end
            end
            FUNC_CHARGER: begin
                if (item.charger_event == CHG_NONE) begin
                    chg_en_next = 1'b0;
                    otg_en_next = 1'b0;
                end else if (item.charger_event inside {[CHG_SDP:CHG_UNKNOWN]}) begin
                    chg_en_next = 1'b1;
                end else if (item.charger_event == CHG_PROVIDE) begin
                    devoff_next = 1'b1;
                    if (mode_reg == MODE_UNKNOWN) begin
                        otg_en_next = 1'b1;
                    end
                end
            end
            FUNC_ID: begin
                if (item.id_event == ID_FALL) begin
                    if (mode_reg == MODE_UNKNOWN) begin
                        sched = SCHED_NOW;
                    end
                    devoff_next = 1'b0;
                end else if (item.id_event == ID_RISE) begin
                    cancel = 1'b1;
                    stop   = 1'b1;
                end else begin
                    cancel = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (stop) begin
            mode_next   = MODE_UNKNOWN;
            chg_en_next = 1'b0;
            otg_en_next = 1'b0;
            devoff_next = 1'b0;
            nvalid      = 1'b1;
            ncode       = NOTIFY_NO_CHARGER;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_UNKNOWN;
            chg_en_reg <= 1'b0;
            otg_en_reg <= 1'b0;
            devoff_reg <= 1'b0;
        end else if (step) begin
            mode_reg   <= mode_next;
            chg_en_reg <= chg_en_next;
            otg_en_reg <= otg_en_next;
            devoff_reg <= devoff_next;
        end
    end

    always_comb begin
        res.notify_valid     = nvalid;
        res.notify_code      = ncode;
        res.schedule         = sched;
        res.cancel_poll      = cancel;
        res.mode_out         = mode_code(mode_next);
        res.id_class         = cls;
        res.charger_flag_out = chg_en_next;
        res.otg_flag_out     = otg_en_next;
        res.devoff_done_out  = devoff_next;
    end

endmodule

// ===== rtl/core/ycm_checker.sv =====
// ----------------------------------------------------------------------------
// ycm_checker
// Port-level checks on the Y-cable mode controller, bound to the top level.
// ----------------------------------------------------------------------------
module ycm_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [ycm_pkg::M_TDATA_W-1:0]     m_tdata
);
    import ycm_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no result right out of reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // notification code only rides with a notification
    a_ncode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[2:1] == NOTIFY_NO_CHARGER)
        else $error("notify code without notification");

    // a classified tick always reschedules with poll or switch delay
    a_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9:8] != CLASS_INVALID
            |-> m_tdata[4:3] == SCHED_POLL || m_tdata[4:3] == SCHED_SWITCH)
        else $error("classified tick without reschedule");

    // a cancel never comes with a reschedule or a class
    a_cancel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> m_tdata[4:3] == SCHED_NONE
            && m_tdata[9:8] == CLASS_INVALID)
        else $error("cancel with reschedule or class");

endmodule

bind y_cable_mode_controller_unit ycm_checker u_ycm_checker (.*);
